// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define ASSERT_CLKRST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk while rst is low.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLKRST(label, !(cond), msg)

`endif

// ----- hdl/lzwbg_pkg.sv -----
// Types and constants shared by the bi-level LZW encoder modules.
`default_nettype none

package lzwbg_pkg;

  // Code field of a queued code; holds the widest code the parameter range allows.
  localparam int CODE_FIELD_W = 12;
  localparam int SIZE_W       = 4;
  localparam int WIDTH_W      = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd2;
  localparam int                SIZE_LIMIT = 8;

  // Queue between the front and the dictionary unit.
  localparam int IN_DEPTH  = 2;
  // Code queue between the dictionary unit and the packer.
  localparam int CQ_DEPTH  = 8;
  localparam int CQ_CNT_W  = 4;
  // Most codes one pixel can produce: prefix, clear, prefix again and end.
  localparam int CQ_ROOM   = 4;
  // Byte queue on the result side.
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic              pixel;
    logic              last;
    logic              first;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic [CODE_FIELD_W-1:0] code;
    logic [WIDTH_W-1:0]      width;
    logic                    last;
  } code_ent_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_ent_t;

endpackage

`default_nettype wire

// ----- hdl/lzwbg_fifo.sv -----
// Small first-word-fall-through queue built from registers.
`default_nettype none
`include "assert_macros.svh"

module lzwbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [WIDTH-1:0]               wr_data,
  output logic                                full,
  input  wire logic                           rd_en,
  output logic [WIDTH-1:0]                    rd_data,
  output logic                                empty,
  output logic [$clog2(DEPTH+1)-1:0]          count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNTW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_fifo_count_bound, count > CNTW'(DEPTH), "fifo count beyond depth")

endmodule

`default_nettype wire

// ----- hdl/lzwbg_front.sv -----
// Input side: accepts pixels, marks the first pixel of each image and attaches its code size.
`default_nettype none

module lzwbg_front #(
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           pixel_bit,
  input  wire logic                           last_pixel,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lzwbg_pkg::SIZE_W-1:0]   code_size,
  output lzwbg_pkg::item_t                    item,
  output logic                                item_empty,
  input  wire logic                           item_pop
);

  localparam int SIZE_TOP = (lzwbg_pkg::SIZE_LIMIT < MAX_CODE_BITS - 1) ?
                            lzwbg_pkg::SIZE_LIMIT : MAX_CODE_BITS - 1;

  logic [lzwbg_pkg::SIZE_W-1:0] size_reg;
  logic [lzwbg_pkg::SIZE_W-1:0] size_eff;
  logic                         first_pend;
  logic                         accept;
  lzwbg_pkg::item_t             new_item;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_comb begin
    size_eff = size_reg;
    if (size_reg < lzwbg_pkg::SIZE_MIN) begin
      size_eff = lzwbg_pkg::SIZE_MIN;
    end else if (size_reg > lzwbg_pkg::SIZE_W'(SIZE_TOP)) begin
      size_eff = lzwbg_pkg::SIZE_W'(SIZE_TOP);
    end
    new_item.pixel = pixel_bit;
    new_item.last  = last_pixel;
    new_item.first = first_pend;
    new_item.size  = size_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg   <= lzwbg_pkg::SIZE_RESET;
      first_pend <= 1'b1;
    end else begin
      if (cfg_valid) begin
        size_reg <= code_size;
      end
      if (accept) begin
        first_pend <= last_pixel;
      end
    end
  end

  lzwbg_fifo #(
    .WIDTH ($bits(lzwbg_pkg::item_t)),
    .DEPTH (lzwbg_pkg::IN_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (new_item),
    .full    (full),
    .rd_en   (item_pop),
    .rd_data (item),
    .empty   (item_empty),
    .count   ()
  );

endmodule

`default_nettype wire

// ----- hdl/lzwbg_dict.sv -----
// Dictionary unit: looks up (prefix, pixel) pairs, adds new codes and issues codes to emit.
`default_nettype none
`include "assert_macros.svh"

module lzwbg_dict #(
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lzwbg_pkg::item_t                 item,
  input  wire logic                             item_empty,
  output logic                                  item_pop,
  output logic                                  cq_push,
  output lzwbg_pkg::code_ent_t                  cq_data,
  input  wire logic [lzwbg_pkg::CQ_CNT_W-1:0]   cq_count
);

  localparam int CW   = MAX_CODE_BITS;
  localparam int IW   = MAX_CODE_BITS + 1;
  localparam int NW   = MAX_CODE_BITS + 1;
  localparam int TBL  = 1 << IW;
  localparam int KEYS = 1 << CW;
  localparam int FW   = lzwbg_pkg::CODE_FIELD_W;
  localparam int WW   = lzwbg_pkg::WIDTH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_CLEAR,
    S_TAIL,
    S_END
  } state_t;

  state_t                       state;
  logic                         pixel_r;
  logic                         last_r;
  logic [IW-1:0]                idx_r;
  logic                         inrange_q;
  logic [CW-1:0]                prefix;
  logic [NW-1:0]                next_code;
  logic [WW-1:0]                code_width;
  logic [lzwbg_pkg::SIZE_W-1:0] act_size;

  // Pair table maps (prefix, pixel) to a code; the key table maps each code back
  // to its pair. A pair is known only when both agree and the code is live.
  logic [CW-1:0] pair_mem [TBL];
  logic [IW-1:0] key_mem  [KEYS];
  logic [CW-1:0] pair_q;
  logic [IW-1:0] key_q;

  logic          start;
  logic          hit;
  logic          grow;
  logic          pair_we;
  logic [IW-1:0] idx_c;
  logic [NW-1:0] next_inc;
  logic [NW-1:0] first_free;
  logic [FW-1:0] clear_cur;

  assign start      = !item_empty &&
                      (cq_count <= lzwbg_pkg::CQ_CNT_W'(lzwbg_pkg::CQ_DEPTH - lzwbg_pkg::CQ_ROOM));
  assign idx_c      = {prefix, item.pixel};
  assign hit        = inrange_q && (key_q == idx_r);
  assign next_inc   = next_code + NW'(1);
  assign grow       = next_inc > (NW'(1) << code_width);
  assign first_free = (NW'(1) << act_size) + NW'(2);
  assign clear_cur  = FW'(1) << act_size;

  always_comb begin
    item_pop = 1'b0;
    cq_push  = 1'b0;
    cq_data  = '0;
    pair_we  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          item_pop = 1'b1;
          if (item.first) begin
            cq_push       = 1'b1;
            cq_data.code  = FW'(1) << item.size;
            cq_data.width = WW'(item.size) + WW'(1);
          end
        end
      end
      S_CHECK: begin
        if (hit) begin
          // A known pair only extends the current string.
        end else begin
          cq_push       = 1'b1;
          cq_data.code  = FW'(prefix);
          cq_data.width = code_width;
          pair_we       = next_code < NW'(KEYS);
        end
      end
      S_CLEAR: begin
        cq_push       = 1'b1;
        cq_data.code  = clear_cur;
        cq_data.width = code_width;
      end
      S_TAIL: begin
        cq_push       = 1'b1;
        cq_data.code  = FW'(prefix);
        cq_data.width = code_width;
      end
      S_END: begin
        cq_push       = 1'b1;
        cq_data.code  = clear_cur + FW'(1);
        cq_data.width = code_width;
        cq_data.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[idx_r]              <= next_code[CW-1:0];
      key_mem[next_code[CW-1:0]]   <= idx_r;
    end
    if (state == S_IDLE) begin
      pair_q <= pair_mem[idx_c];
    end
    if (state == S_LOOK) begin
      key_q <= key_mem[pair_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prefix     <= '0;
      next_code  <= NW'(6);
      code_width <= WW'(3);
      act_size   <= lzwbg_pkg::SIZE_RESET;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pixel_r <= item.pixel;
            last_r  <= item.last;
            idx_r   <= idx_c;
            if (item.first) begin
              act_size   <= item.size;
              code_width <= WW'(item.size) + WW'(1);
              next_code  <= (NW'(1) << item.size) + NW'(2);
              prefix     <= CW'(item.pixel);
              state      <= item.last ? S_TAIL : S_IDLE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          inrange_q <= (NW'(pair_q) >= first_free) && (NW'(pair_q) < next_code);
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            prefix <= pair_q;
            state  <= last_r ? S_TAIL : S_IDLE;
          end else begin
            prefix <= CW'(pixel_r);
            if (grow && (code_width == WW'(CW))) begin
              // The table is full at the widest code: restart it behind a clear code.
              state <= S_CLEAR;
            end else begin
              next_code <= next_inc;
              if (grow) begin
                code_width <= code_width + WW'(1);
              end
              state <= last_r ? S_TAIL : S_IDLE;
            end
          end
        end
        S_CLEAR: begin
          next_code  <= first_free;
          code_width <= WW'(act_size) + WW'(1);
          state      <= last_r ? S_TAIL : S_IDLE;
        end
        S_TAIL: begin
          state <= S_END;
        end
        S_END: begin
          prefix <= '0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLKRST(a_cq_room, cq_push |-> (cq_count < lzwbg_pkg::CQ_CNT_W'(lzwbg_pkg::CQ_DEPTH)),
                 "code pushed into a full code queue")
  `ASSERT_NEVER(a_code_fits, next_code > (NW'(1) << code_width),
                "next free code does not fit the current code width")
  `ASSERT_NEVER(a_width_bound, code_width > WW'(CW), "code width beyond the maximum")

endmodule

`default_nettype wire

// ----- hdl/lzwbg_pack.sv -----
// Packer: turns variable-width codes into bytes, earliest bit first, and flushes at image end.
`default_nettype none
`include "assert_macros.svh"

module lzwbg_pack (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lzwbg_pkg::code_ent_t   code_in,
  input  wire logic                   code_empty,
  output logic                        code_pop,
  output logic                        ob_push,
  output lzwbg_pkg::byte_ent_t        ob_data,
  input  wire logic                   ob_full
);

  localparam int ACC_W = lzwbg_pkg::CODE_FIELD_W + 7;
  localparam int BW    = $clog2(ACC_W + 1);

  logic             busy;
  logic             fin;
  logic [ACC_W-1:0] acc;
  logic [BW-1:0]    bits;
  logic [ACC_W-1:0] code_masked;
  logic             has_byte;
  logic             flush;

  assign code_masked = ACC_W'(code_in.code) &
                       ((ACC_W'(1) << code_in.width) - ACC_W'(1));
  assign code_pop    = !busy && !code_empty;
  assign has_byte    = bits >= BW'(8);
  assign flush       = fin && !has_byte && (bits != '0);

  always_comb begin
    ob_push      = 1'b0;
    ob_data.data = acc[7:0];
    ob_data.last = 1'b0;
    if (busy && !ob_full) begin
      if (has_byte) begin
        ob_push      = 1'b1;
        ob_data.last = fin && (bits == BW'(8));
      end else if (flush) begin
        ob_push      = 1'b1;
        ob_data.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      acc  <= '0;
      bits <= '0;
    end else if (!busy) begin
      if (!code_empty) begin
        acc  <= ACC_W'(acc[6:0]) | (code_masked << bits);
        bits <= bits + BW'(code_in.width);
        fin  <= code_in.last;
        busy <= 1'b1;
      end
    end else if (has_byte) begin
      if (!ob_full) begin
        acc  <= acc >> 8;
        bits <= bits - BW'(8);
      end
    end else if (flush) begin
      if (!ob_full) begin
        acc  <= '0;
        bits <= '0;
        busy <= 1'b0;
      end
    end else begin
      // Fewer than eight bits left: keep them for the next code, or drop state at image end.
      busy <= 1'b0;
      if (fin) begin
        acc  <= '0;
        bits <= '0;
      end
    end
  end

  `ASSERT_CLKRST(a_idle_partial, !busy |-> (bits < BW'(8)),
                 "packer idle with a whole byte still held")

endmodule

`default_nettype wire

// ----- hdl/lzw_bilevel_gif_encoder_core.sv -----
// Top level of the bi-level GIF-style LZW encoder.
`default_nettype none

// GIF-style LZW encoder for one-bit pixels. Pixels enter through a push/full queue,
// one per transfer; the packed code stream leaves one byte per transfer through an
// empty/pop queue, with last_byte set on the final byte of each image. The first pixel
// of an image sends the clear code and takes the code size written on the config port,
// so write code_size between images. The dictionary unit takes a pixel through a pair-table
// read, a code-to-pair read and a decision, and takes the first pixel of an image in its
// idle step alone; a restart of the full table adds a clear-code step, and the last pixel
// of an image adds a tail step and an end step. The packer takes in a code while idle,
// then sends each whole byte; the partial byte that closes an image leaves in the code's final step.
// The pair table holds 2^(MAX_CODE_BITS+1) codes and the code-to-pair table
// 2^MAX_CODE_BITS pairs; a pair counts as known only when both tables agree on a live
// code, so neither table is cleared and no clearing pass follows reset.
module lzw_bilevel_gif_encoder_core #(
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           pixel_bit,
  input  wire logic                           last_pixel,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_byte,
  output logic                                last_byte,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lzwbg_pkg::SIZE_W-1:0]   code_size
);

  lzwbg_pkg::item_t                 item;
  logic                             item_empty;
  logic                             item_pop;
  logic                             cq_push;
  lzwbg_pkg::code_ent_t             cq_wdata;
  lzwbg_pkg::code_ent_t             cq_rdata;
  logic                             cq_empty;
  logic                             cq_pop;
  logic [lzwbg_pkg::CQ_CNT_W-1:0]   cq_count;
  logic                             ob_push;
  lzwbg_pkg::byte_ent_t             ob_wdata;
  lzwbg_pkg::byte_ent_t             ob_rdata;
  logic                             ob_full;

  lzwbg_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_bit  (pixel_bit),
    .last_pixel (last_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .code_size  (code_size),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop)
  );

  lzwbg_dict #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dict (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .cq_push    (cq_push),
    .cq_data    (cq_wdata),
    .cq_count   (cq_count)
  );

  lzwbg_fifo #(
    .WIDTH ($bits(lzwbg_pkg::code_ent_t)),
    .DEPTH (lzwbg_pkg::CQ_DEPTH)
  ) u_code_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_data (cq_wdata),
    .full    (),
    .rd_en   (cq_pop),
    .rd_data (cq_rdata),
    .empty   (cq_empty),
    .count   (cq_count)
  );

  lzwbg_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .code_in    (cq_rdata),
    .code_empty (cq_empty),
    .code_pop   (cq_pop),
    .ob_push    (ob_push),
    .ob_data    (ob_wdata),
    .ob_full    (ob_full)
  );

  lzwbg_fifo #(
    .WIDTH ($bits(lzwbg_pkg::byte_ent_t)),
    .DEPTH (lzwbg_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ob_push),
    .wr_data (ob_wdata),
    .full    (ob_full),
    .rd_en   (pop),
    .rd_data (ob_rdata),
    .empty   (empty),
    .count   ()
  );

  assign out_byte  = ob_rdata.data;
  assign last_byte = ob_rdata.last;

endmodule

`default_nettype wire
